FILE: rtl/core/lz4bd_pkg.sv
// ----------------------------------------------------------------------------
// lz4bd_pkg
// Shared types and constants for the LZ4 block decoder core.
// ----------------------------------------------------------------------------
package lz4bd_pkg;

   localparam int WINDOW_BYTES_DEF = 65536;
   localparam int OUT_BYTES_DEF    = 8;
   localparam int MAX_RESULTS      = 32;

   localparam logic [1:0] ERR_NONE   = 2'd0;
   localparam logic [1:0] ERR_OFFSET = 2'd1;
   localparam logic [1:0] ERR_TRUNC  = 2'd2;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [63:0] out_data;
      logic [3:0]  out_count;
      logic        out_last;
      logic [1:0]  out_error;
      logic [31:0] out_total;
   } rsp_type;

   // stream parse phase, one-hot
   typedef enum logic [6:0] {
      PH_TOKEN  = 7'b0000001,
      PH_LITEXT = 7'b0000010,
      PH_LIT    = 7'b0000100,
      PH_OFFLO  = 7'b0001000,
      PH_OFFHI  = 7'b0010000,
      PH_MATEXT = 7'b0100000,
      PH_DRAIN  = 7'b1000000
   } phase_type;

   // controller states, one-hot
   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_DECODE = 6'b000010,
      ST_RD     = 6'b000100,
      ST_WR     = 6'b001000,
      ST_FLUSH  = 6'b010000,
      ST_FINAL  = 6'b100000
   } state_type;

   typedef struct packed {
      logic load;
      logic dec;
      logic rd;
      logic wr;
      logic flush;
      logic fin;
   } cmd_type;

   typedef struct packed {
      logic dec_push;
      logic dec_copy;
      logic len_zero;
      logic wr_push;
      logic acc_any;
      logic can_push;
      logic can_move;
   } stat_type;

endpackage

FILE: rtl/core/lz4bd_ctrl.sv
// ----------------------------------------------------------------------------
// lz4bd_ctrl
// Sequencer: steps each input byte through decode, match copy and result hand-off.
// ----------------------------------------------------------------------------
module lz4bd_ctrl
   import lz4bd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (!stat.dec_push || stat.can_push) begin
               cmd.dec  = 1'b1;
               state_in = stat.dec_copy ? ST_RD : ST_FINAL;
            end
         end
         ST_RD: begin
            if (stat.len_zero) begin
               state_in = ST_FLUSH;
            end else begin
               cmd.rd   = 1'b1;
               state_in = ST_WR;
            end
         end
         ST_WR: begin
            if (!stat.wr_push || stat.can_push) begin
               cmd.wr   = 1'b1;
               state_in = ST_RD;
            end
         end
         ST_FLUSH: begin
            if (!stat.acc_any || stat.can_push) begin
               cmd.flush = 1'b1;
               state_in  = ST_FINAL;
            end
         end
         ST_FINAL: begin
            if (stat.can_move) begin
               cmd.fin  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: rtl/core/lz4bd_dpath.sv
// ----------------------------------------------------------------------------
// lz4bd_dpath
// Parse registers, history window, match packer and result registers.
// ----------------------------------------------------------------------------
module lz4bd_dpath
   import lz4bd_pkg::*;
#(
   parameter int WINDOW_BYTES = WINDOW_BYTES_DEF,
   parameter int OUT_BYTES    = OUT_BYTES_DEF
) (
   input  logic     clock,
   input  logic     reset,
   input  req_type  req_data,
   input  cmd_type  cmd,
   output stat_type stat,
   input  logic     rsp_ready,
   output logic     rsp_valid,
   output rsp_type  rsp_data
);

   localparam int AW   = $clog2(WINDOW_BYTES);
   localparam int PACK = (OUT_BYTES > 8) ? 8 : OUT_BYTES;
   localparam int RCW  = $clog2(MAX_RESULTS + 1);

   logic [7:0]  mem [WINDOW_BYTES];
   logic [7:0]  rd_data_ff;

   phase_type   phase_ff;
   logic [7:0]  byte_ff;
   logic        last_ff;
   logic [31:0] lit_left_ff;
   logic [3:0]  nib_ff;
   logic [15:0] off_ff;
   logic [1:0]  err_ff;
   logic [AW-1:0] wp_ff;
   logic [31:0] bw_ff;
   logic [7:0]  mlen_ff;
   logic [63:0] acc_ff;
   logic [3:0]  acc_cnt_ff;
   logic        stg_valid_ff;
   rsp_type     stg_ff;
   logic [RCW-1:0] res_cnt_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;

   logic [15:0] off_new;
   logic        off_bad;
   logic [16:0] wp_inc;
   logic [AW-1:0] wp_next;
   logic [31:0] bw_next;
   logic [16:0] src_wide;
   logic [AW-1:0] src_addr;
   logic [63:0] acc_new;
   logic [3:0]  cnt_new;
   logic        out_busy;
   logic        room;
   logic [32:0] lit_sum;
   logic [1:0]  err_fin;

   assign off_new  = {byte_ff, off_ff[7:0]};
   assign off_bad  = (off_new == 16'd0) || ({16'd0, off_new} > bw_ff)
                     || (17'(off_new) > 17'(WINDOW_BYTES));
   assign wp_inc   = 17'(wp_ff) + 17'd1;
   assign wp_next  = (wp_inc == 17'(WINDOW_BYTES)) ? '0 : AW'(wp_inc);
   assign bw_next  = (bw_ff == 32'hFFFF_FFFF) ? bw_ff : bw_ff + 32'd1;
   assign src_wide = (17'(wp_ff) >= 17'(off_ff))
                     ? 17'(wp_ff) - 17'(off_ff)
                     : 17'(wp_ff) + 17'(WINDOW_BYTES) - 17'(off_ff);
   assign src_addr = AW'(src_wide);
   assign acc_new  = acc_ff | ({56'd0, rd_data_ff} << {acc_cnt_ff[2:0], 3'b000});
   assign cnt_new  = acc_cnt_ff + 4'd1;
   assign out_busy = rsp_valid_ff && !rsp_ready;
   assign room     = res_cnt_ff < RCW'(MAX_RESULTS);
   assign lit_sum  = {1'b0, lit_left_ff} + {25'd0, byte_ff};
   assign err_fin  = ((phase_ff != PH_TOKEN) && (phase_ff != PH_OFFLO)
                      && (err_ff == ERR_NONE)) ? ERR_TRUNC : err_ff;

   assign stat.dec_push = (phase_ff == PH_LIT) || ((phase_ff == PH_OFFHI) && off_bad);
   assign stat.dec_copy = ((phase_ff == PH_OFFHI) && !off_bad) || (phase_ff == PH_MATEXT);
   assign stat.len_zero = (mlen_ff == 8'd0);
   assign stat.wr_push  = (cnt_new == 4'(PACK));
   assign stat.acc_any  = (acc_cnt_ff != 4'd0);
   assign stat.can_push = !stg_valid_ff || !out_busy || !room;
   assign stat.can_move = !out_busy;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // window: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.dec && (phase_ff == PH_LIT)) begin
         mem[wp_ff] <= byte_ff;
      end else if (cmd.wr) begin
         mem[wp_ff] <= rd_data_ff;
      end
      if (cmd.rd) begin
         rd_data_ff <= mem[src_addr];
      end
   end

   // result staging and output register
   logic    push_en;
   rsp_type push_val;

   always_comb begin
      push_en  = 1'b0;
      push_val = '0;
      if (cmd.dec && (phase_ff == PH_LIT)) begin
         push_en  = 1'b1;
         push_val = '{out_data: {56'd0, byte_ff}, out_count: 4'd1, out_last: 1'b0,
                      out_error: err_ff, out_total: bw_next};
      end else if (cmd.dec && (phase_ff == PH_OFFHI)) begin
         push_en  = 1'b1;
         push_val = '{out_data: 64'd0, out_count: 4'd0, out_last: 1'b0,
                      out_error: ERR_OFFSET, out_total: bw_ff};
      end else if (cmd.wr && stat.wr_push) begin
         push_en  = 1'b1;
         push_val = '{out_data: acc_new, out_count: cnt_new, out_last: 1'b0,
                      out_error: err_ff, out_total: bw_next};
      end else if (cmd.flush && stat.acc_any) begin
         push_en  = 1'b1;
         push_val = '{out_data: acc_ff, out_count: acc_cnt_ff, out_last: 1'b0,
                      out_error: err_ff, out_total: bw_ff};
      end
      // in the offset high phase a result is pushed only on a bad offset
      if (cmd.dec && (phase_ff == PH_OFFHI) && !off_bad) begin
         push_en = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         stg_valid_ff <= 1'b0;
         res_cnt_ff   <= '0;
      end else begin
         if (push_en && room) begin
            if (stg_valid_ff) begin
               rsp_ff       <= stg_ff;
               rsp_valid_ff <= 1'b1;
            end else if (rsp_ready) begin
               rsp_valid_ff <= 1'b0;
            end
            stg_ff       <= push_val;
            stg_valid_ff <= 1'b1;
            res_cnt_ff   <= res_cnt_ff + RCW'(1);
         end else if (cmd.fin) begin
            stg_valid_ff <= 1'b0;
            res_cnt_ff   <= '0;
            if (last_ff) begin
               rsp_valid_ff      <= 1'b1;
               rsp_ff.out_data   <= stg_valid_ff ? stg_ff.out_data : 64'd0;
               rsp_ff.out_count  <= stg_valid_ff ? stg_ff.out_count : 4'd0;
               rsp_ff.out_last   <= 1'b1;
               rsp_ff.out_error  <= err_fin;
               rsp_ff.out_total  <= bw_ff;
            end else if (stg_valid_ff) begin
               rsp_valid_ff <= 1'b1;
               rsp_ff       <= stg_ff;
            end else if (rsp_ready) begin
               rsp_valid_ff <= 1'b0;
            end
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // parse state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_TOKEN;
         lit_left_ff <= '0;
         nib_ff      <= '0;
         off_ff      <= '0;
         err_ff      <= ERR_NONE;
         wp_ff       <= '0;
         bw_ff       <= '0;
         mlen_ff     <= '0;
         acc_ff      <= '0;
         acc_cnt_ff  <= '0;
      end else begin
         if (cmd.dec) begin
            case (phase_ff)
               PH_TOKEN: begin
                  nib_ff <= byte_ff[3:0];
                  if (byte_ff[7:4] == 4'hF) begin
                     lit_left_ff <= 32'd15;
                     phase_ff    <= PH_LITEXT;
                  end else if (byte_ff[7:4] != 4'h0) begin
                     lit_left_ff <= {28'd0, byte_ff[7:4]};
                     phase_ff    <= PH_LIT;
                  end else begin
                     phase_ff <= PH_OFFLO;
                  end
               end
               PH_LITEXT: begin
                  lit_left_ff <= lit_sum[32] ? 32'hFFFF_FFFF : lit_sum[31:0];
                  if (byte_ff != 8'hFF) begin
                     phase_ff <= PH_LIT;
                  end
               end
               PH_LIT: begin
                  wp_ff <= wp_next;
                  bw_ff <= bw_next;
                  if (lit_left_ff <= 32'd1) begin
                     lit_left_ff <= '0;
                     phase_ff    <= PH_OFFLO;
                  end else begin
                     lit_left_ff <= lit_left_ff - 32'd1;
                  end
               end
               PH_OFFLO: begin
                  off_ff   <= {8'd0, byte_ff};
                  phase_ff <= PH_OFFHI;
               end
               PH_OFFHI: begin
                  off_ff <= off_new;
                  if (off_bad) begin
                     err_ff   <= ERR_OFFSET;
                     phase_ff <= PH_DRAIN;
                  end else if (nib_ff == 4'hF) begin
                     mlen_ff  <= 8'd19;
                     phase_ff <= PH_MATEXT;
                  end else begin
                     mlen_ff  <= {4'd0, nib_ff} + 8'd4;
                     phase_ff <= PH_TOKEN;
                  end
               end
               PH_MATEXT: begin
                  mlen_ff <= byte_ff;
                  if (byte_ff != 8'hFF) begin
                     phase_ff <= PH_TOKEN;
                  end
               end
               default: begin
               end
            endcase
         end
         if (cmd.wr) begin
            wp_ff   <= wp_next;
            bw_ff   <= bw_next;
            mlen_ff <= mlen_ff - 8'd1;
            if (stat.wr_push) begin
               acc_ff     <= '0;
               acc_cnt_ff <= '0;
            end else begin
               acc_ff     <= acc_new;
               acc_cnt_ff <= cnt_new;
            end
         end
         if (cmd.flush) begin
            acc_ff     <= '0;
            acc_cnt_ff <= '0;
         end
         if (cmd.fin && last_ff) begin
            phase_ff    <= PH_TOKEN;
            lit_left_ff <= '0;
            nib_ff      <= '0;
            off_ff      <= '0;
            err_ff      <= ERR_NONE;
            wp_ff       <= '0;
            bw_ff       <= '0;
         end
      end
   end

   // latched input transfer
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         byte_ff <= req_data.in_byte;
         last_ff <= req_data.in_last;
      end
   end

endmodule

FILE: rtl/core/lz4_block_decoder_core.sv
// ----------------------------------------------------------------------------
// lz4_block_decoder_core
// Streaming LZ4 block decoder: one compressed byte in, packed decoded bytes out.
// ----------------------------------------------------------------------------
//  channel   ports                         transfer
//  req       req_valid/req_ready/req_data  one compressed byte plus last flag
//  rsp       rsp_valid/rsp_ready/rsp_data  up to 8 decoded bytes, count, status
//
// Steps: a byte that yields no match goes through accept, decode and hand-off.
// Match bytes are copied from the window with a read and then a write per byte,
// set by the single registered read port; a match ends with the closing length
// check and the partial-word flush.
// Reset: synchronous, active high; clears parse state and the result path.
// The window has no reset; reads only touch bytes already written this block.
// Stalls: a full result register holds the sequencer until rsp takes a transfer.
module lz4_block_decoder_core
   import lz4bd_pkg::*;
#(
   parameter int WINDOW_BYTES = WINDOW_BYTES_DEF,
   parameter int OUT_BYTES    = OUT_BYTES_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   cmd_type  cmd;
   stat_type stat;

   // sequencer
   lz4bd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // window, parse registers and result path
   lz4bd_dpath #(
      .WINDOW_BYTES (WINDOW_BYTES),
      .OUT_BYTES    (OUT_BYTES)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
